>>> rtl/assert_macros.svh
// Assertion helpers: clocked property with active-low disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FDS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: %m");

`define FDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

`define FDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define FDS_ASSERT(lbl, clk, rst_n, prop)
`define FDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/fds_pkg.sv
package fds_pkg;

    localparam int Z_W           = 32;
    localparam int DEPTH_W       = 32;
    localparam int ID_W          = 6;
    localparam int MAX_FACES_DEF = 64;

    typedef struct packed {
        logic                      valid;
        logic signed [DEPTH_W-1:0] depth;
        logic [ID_W-1:0]           id;
    } t_entry;

    typedef struct packed {
        logic shift;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_DRAIN,
        ST_UNLOAD
    } t_state;

    // floor of the four-corner sum over four; sum kept at 34 bits
    function automatic logic signed [DEPTH_W-1:0] face_depth(
        input logic [Z_W-1:0] a,
        input logic [Z_W-1:0] b,
        input logic [Z_W-1:0] c,
        input logic [Z_W-1:0] d
    );
        logic signed [Z_W+1:0] sum;
        sum = $signed({{2{a[Z_W-1]}}, a}) + $signed({{2{b[Z_W-1]}}, b})
            + $signed({{2{c[Z_W-1]}}, c}) + $signed({{2{d[Z_W-1]}}, d});
        return $signed(sum[Z_W+1:2]);
    endfunction

endpackage

>>> rtl/fds_cell.sv
module fds_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fds_pkg::t_cell_ctl i_ctl,
    input  fds_pkg::t_entry   i_in,
    input  fds_pkg::t_entry   i_below,
    output fds_pkg::t_entry   o_pass,
    output fds_pkg::t_entry   o_held
);

    fds_pkg::t_entry r_held, n_held;
    fds_pkg::t_entry r_pass, n_pass;

    always_comb begin
        n_held       = r_held;
        n_pass       = i_in;
        n_pass.valid = 1'b0;
        if (i_ctl.shift) begin
            n_held = i_below;
        end else if (i_in.valid) begin
            if (!r_held.valid) begin
                n_held = i_in;
            // equal depth: lower arrival number stays ahead
            end else if (($signed(i_in.depth) > $signed(r_held.depth))
                         || ((i_in.depth == r_held.depth) && (i_in.id < r_held.id))) begin
                n_held = i_in;
                n_pass = r_held;
            end else begin
                n_pass = i_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_pass = r_pass;
    assign o_held = r_held;

endmodule

>>> rtl/face_depth_sort_core.sv
// Painter's depth sort of quad faces. Each input beat is one face (four corner
// depths); its depth is floor(sum/4). Faces are numbered in arrival order and
// enter a chain of MAX_FACES insertion cells at one beat per cycle. The beat
// with tlast closes the set: input then stalls while the chain settles, after
// which the n stored faces leave one beat per cycle while the sink is ready, in
// descending depth (ties in arrival order), then input opens again. Faces past
// capacity are discarded and reported in tuser on every result of the set.
`include "assert_macros.svh"

module face_depth_sort_core #(
    parameter int MAX_FACES = fds_pkg::MAX_FACES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // z_a, z_b, z_c, z_d
    input  logic         i_s_tlast,   // last_face
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [39:0]  o_m_tdata,   // face_id, depth, zero pad
    output logic         o_m_tlast,   // last_result
    output logic         o_m_tuser    // dropped
);

    localparam int TW = $clog2(MAX_FACES + 1);
    localparam logic [TW-1:0] FULL = TW'(MAX_FACES);

    fds_pkg::t_state    r_state, n_state;
    logic [TW-1:0]      r_total, n_total;
    logic [TW-1:0]      r_cnt, n_cnt;
    logic               r_ovf, n_ovf;
    fds_pkg::t_entry    r_ent, n_ent;
    fds_pkg::t_cell_ctl w_ctl;
    fds_pkg::t_entry    w_pass [MAX_FACES];
    fds_pkg::t_entry    w_held [MAX_FACES+1];
    fds_pkg::t_entry    w_tail;
    logic               w_in_acc, w_out_acc;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;

    always_comb begin
        n_state       = r_state;
        n_total       = r_total;
        n_cnt         = r_cnt;
        n_ovf         = r_ovf;
        n_ent.valid   = 1'b0;
        n_ent.depth   = fds_pkg::face_depth(i_s_tdata[31:0], i_s_tdata[63:32],
                                            i_s_tdata[95:64], i_s_tdata[127:96]);
        n_ent.id      = fds_pkg::ID_W'(r_total);
        o_s_tready    = 1'b0;
        o_m_tvalid    = 1'b0;
        w_ctl.shift   = 1'b0;
        unique case (r_state)
            fds_pkg::ST_FILL: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (r_total < FULL) begin
                        n_ent.valid = 1'b1;
                        n_total     = r_total + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_state = fds_pkg::ST_DRAIN;
                        n_cnt   = '0;
                    end
                end
            end
            fds_pkg::ST_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == FULL) begin
                    n_state = fds_pkg::ST_UNLOAD;
                end
            end
            fds_pkg::ST_UNLOAD: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    w_ctl.shift = 1'b1;
                    n_total     = r_total - 1'b1;
                    if (r_total == TW'(1)) begin
                        n_state = fds_pkg::ST_FILL;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = fds_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fds_pkg::ST_FILL;
            r_total     <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_ent.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_ent   <= n_ent;
        end
    end

    assign w_pass[0]         = r_ent;
    assign w_held[MAX_FACES] = '0;

    for (genvar k = 0; k < MAX_FACES; k++) begin : g_cell
        if (k < MAX_FACES - 1) begin : g_mid
            fds_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_in    (w_pass[k]),
                .i_below (w_held[k+1]),
                .o_pass  (w_pass[k+1]),
                .o_held  (w_held[k])
            );
        end else begin : g_end
            fds_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_in    (w_pass[k]),
                .i_below (w_held[k+1]),
                .o_pass  (w_tail),
                .o_held  (w_held[k])
            );
        end
    end

    assign o_m_tdata = {2'b00, w_held[0].depth, w_held[0].id};
    assign o_m_tlast = (r_total == TW'(1));
    assign o_m_tuser = r_ovf;

    `FDS_ASSERT(a_no_spill, i_clk, i_rst_n, !w_tail.valid)
    `FDS_ASSERT(a_total_bound, i_clk, i_rst_n, r_total <= FULL)
    `FDS_ASSERT(a_one_side, i_clk, i_rst_n, !(o_s_tready && o_m_tvalid))
    `FDS_ASSERT_IMPL(a_head_valid, i_clk, i_rst_n, o_m_tvalid, w_held[0].valid)
    `FDS_ASSERT_NEXT(a_set_closed, i_clk, i_rst_n, w_out_acc && o_m_tlast,
                     r_total == '0 && !r_ovf && !w_held[0].valid)
    `FDS_ASSERT_NEXT(a_fill_drop, i_clk, i_rst_n, w_in_acc && r_total == FULL, r_ovf)

endmodule

>>> dv/testbench.sv
module testbench;

    localparam int MAX_FACES   = fds_pkg::MAX_FACES_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 8;

    typedef struct packed {
        logic [fds_pkg::ID_W-1:0]           id;
        logic signed [fds_pkg::DEPTH_W-1:0] depth;
        logic                               last;
        logic                               dropped;
    } t_ranked;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata  = '0;   // z_a, z_b, z_c, z_d
    logic         i_s_tlast  = 1'b0; // last_face
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [39:0]  o_m_tdata;         // face_id, depth, zero pad
    logic         o_m_tlast;         // last_result
    logic         o_m_tuser;         // dropped

    logic signed [fds_pkg::DEPTH_W-1:0] held_depth[$];
    bit                                 held_overflow = 1'b0;
    t_ranked                            ranked_q[$];

    int mismatches  = 0;
    int cycle_count = 0;
    int faces_sent  = 0;
    int hold_left   = 0;
    bit steady      = 1'b0;

    face_depth_sort_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // floor of the corner sum over four, formed in 64 bits
    function automatic logic signed [fds_pkg::DEPTH_W-1:0] corner_mean(logic [3:0][31:0] z);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++) begin
            acc += longint'($signed(z[k]));
        end
        return fds_pkg::DEPTH_W'(acc >>> 2);
    endfunction

    function automatic void rank_face(logic [3:0][31:0] z, logic last);
        int      order[$];
        int      pos;
        t_ranked r;
        if (held_depth.size() < MAX_FACES) begin
            held_depth.push_back(corner_mean(z));
        end else begin
            held_overflow = 1'b1;
        end
        if (!last) return;
        // stable descending order: a face only passes strictly shallower ones
        for (int i = 0; i < held_depth.size(); i++) begin
            pos = order.size();
            while (pos > 0 && held_depth[order[pos-1]] < held_depth[i]) pos--;
            order.insert(pos, i);
        end
        for (int i = 0; i < order.size(); i++) begin
            r.id      = fds_pkg::ID_W'(order[i]);
            r.depth   = held_depth[order[i]];
            r.last    = (i == order.size() - 1);
            r.dropped = held_overflow;
            ranked_q.push_back(r);
        end
        held_depth.delete();
        held_overflow = 1'b0;
    endfunction

    task automatic report(string msg);
        $display("[cycle %0d] ERROR: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // result checker
    initial begin
        t_ranked want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (ranked_q.size() == 0) begin
                    report($sformatf("unexpected beat id=%0d depth=%0d",
                                     o_m_tdata[5:0], $signed(o_m_tdata[37:6])));
                end else begin
                    want = ranked_q.pop_front();
                    check_field("face_id", o_m_tdata[5:0], want.id);
                    check_field("depth", $signed(o_m_tdata[37:6]), want.depth);
                    check_field("last_result", o_m_tlast, want.last);
                    check_field("dropped", o_m_tuser, want.dropped);
                end
            end
        end
    end

    // result-side ready, with counted hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= i_rst_n && !idle_now();
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_face(logic [31:0] za, logic [31:0] zb, logic [31:0] zc,
                             logic [31:0] zd, logic last);
        logic [3:0][31:0] z;
        z = {zd, zc, zb, za};
        while (idle_now()) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= z;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        rank_face(z, last);
        faces_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_corner(int flavor);
        logic [31:0] pick[5];
        pick = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1};
        case (flavor)
            0: begin
                return $urandom();
            end
            1: begin
                return 32'($signed($urandom_range(6)) - 3);
            end
            default: begin
                return pick[$urandom_range(4)];
            end
        endcase
    endfunction

    task automatic send_set(int n);
        int roll;
        int flavor;
        for (int i = 0; i < n; i++) begin
            roll   = $urandom_range(99);
            flavor = (roll < 60) ? 0 : (roll < 90) ? 1 : 2;
            send_face(rand_corner(flavor), rand_corner(flavor), rand_corner(flavor),
                      rand_corner(flavor), i == n - 1);
        end
    endtask

    task automatic test_corner_faces();
        send_face(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        send_face(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_face(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        send_face(32'h1, 32'h1, 32'h1, 32'h0, 1'b0);
        send_face(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_face(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0);
        send_face(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 1'b0);
        send_face(32'h3, 32'h0, 32'h0, 32'h0, 1'b0);
        send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_face(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        send_face(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'h8765_4321, 1'b1);
        // equal depths keep arrival order
        send_face(32'h5, 32'h5, 32'h5, 32'h5, 1'b0);
        send_face(32'h5, 32'h5, 32'h5, 32'h5, 1'b1);
        // ascending input, fully reversed on output
        send_face(32'h4, 32'h0, 32'h0, 32'h0, 1'b0);
        send_face(32'h8, 32'h0, 32'h0, 32'h0, 1'b0);
        send_face(32'hC, 32'h0, 32'h0, 32'h0, 1'b0);
        send_face(32'h10, 32'h0, 32'h0, 32'h0, 1'b1);
    endtask

    task automatic test_full_store();
        send_set(MAX_FACES);
        // the last-marked beat itself falls past capacity
        send_set(MAX_FACES + 2);
    endtask

    task automatic test_random_sets();
        int n;
        while (faces_sent < 365) begin
            n = ($urandom_range(99) < 90) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            send_set(n);
        end
    endtask

    task automatic test_no_gaps();
        steady = 1'b1;
        send_set(5);
        send_set(1);
        send_set(7);
        steady = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_left = 300;
        send_set(6);
        send_set(4);
        send_set(9);
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_corner_faces();
        test_full_store();
        test_no_gaps();
        test_output_hold();
        test_random_sets();
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (MAX_FACES + 8) @(posedge i_clk);
        if (mismatches == 0 && ranked_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/fds_pkg.sv
rtl/fds_cell.sv
rtl/face_depth_sort_core.sv
dv/testbench.sv
